>>> design/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that ante at one edge implies cons at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/mcvm_pkg.sv
`default_nettype none
package mcvm_pkg;

  localparam int MAX_VOICES       = 16;
  localparam int VIDX_W           = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int SINE_TABLE_BITS  = 10;
  localparam int DECAY_TABLE_BITS = 10;
  localparam int SINE_N           = 1 << SINE_TABLE_BITS;
  localparam int DECAY_N          = 1 << DECAY_TABLE_BITS;
  localparam int DEC_SHIFT        = DECAY_TABLE_BITS - 3;

  localparam int CUR_W   = 48;
  localparam int E_W     = 20;   // elapsed samples inside one voice span
  localparam int SPAN_W  = 20;
  localparam int ENV_W   = 17;
  localparam int SIN_W   = 15;
  localparam int ACC_W   = 17 + VIDX_W;
  localparam int DIV_W   = 32;
  localparam int QUO_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;
  localparam int VOICE_W = CUR_W + 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // item kinds
  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_RENDER = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // tick kinds
  localparam logic [1:0] TONE_ACCENT = 2'd0;
  localparam logic [1:0] TONE_BEAT   = 2'd1;
  localparam logic [1:0] TONE_SUB    = 2'd2;
  localparam logic [1:0] TONE_UNUSED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT_STEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT_GAIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_STEP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_GAIN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_STEP    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_GAIN    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 4'd7;

  typedef logic [SIN_W-1:0] sine_tab_t [SINE_N+1];
  typedef logic [ENV_W-1:0] env_tab_t [DECAY_N];

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [15:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  // Quarter-wave sine in Q15 from a Q30 Taylor series.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] q;
    for (int i = 0; i <= SINE_N; i++) begin
      a    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed(a);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = '0;
      q = ($unsigned(sum) + 64'd16384) >> 15;
      tab[i] = (q > 64'd32767) ? 15'd32767 : q[SIN_W-1:0];
    end
    return tab;
  endfunction

  // Exponential decay envelope in Q16, rounded from a Q32 power series.
  function automatic env_tab_t build_env();
    env_tab_t    tab;
    logic [63:0] y;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] rnd;
    y    = 64'd1 << (35 - DECAY_TABLE_BITS);
    term = 64'd1 << 32;
    sum  = 64'sd1 <<< 32;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if ((k & 1) != 0) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    r = $unsigned(sum);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    x = 64'd1 << 32;
    for (int i = 0; i < DECAY_N; i++) begin
      if (i > 0) x = (x * r) >> 32;
      rnd    = (x + 64'd32768) >> 16;
      tab[i] = rnd[ENV_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_Q15  = build_sine();
  localparam env_tab_t  DECAY_ENV = build_env();

endpackage
`default_nettype wire

>>> design/mcvm_in_if.sv
`default_nettype none
interface mcvm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [47:0] start_req;
  logic [1:0]  tick_kind;

  modport source (output valid, kind, start_req, tick_kind, input ready);
  modport sink (input valid, kind, start_req, tick_kind, output ready);
endinterface
`default_nettype wire

>>> design/mcvm_out_if.sv
`default_nettype none
interface mcvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [47:0]        position;
  logic               dropped;

  modport source (output valid, sample, position, dropped, input ready);
  modport sink (input valid, sample, position, dropped, output ready);
endinterface
`default_nettype wire

>>> design/mcvm_ram.sv
`default_nettype none
module mcvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/mcvm_div.sv
`default_nettype none
module mcvm_div
  import mcvm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  localparam int CNT_W = $clog2(DIV_W) + 1;

  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [16:0]      trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q, num_q[DIV_W-1]};
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q[QUO_W-1:0];
endmodule
`default_nettype wire

>>> design/metronome_click_voice_mixer.sv
// Metronome click mixer: a pool of MAX_VOICES click voices, each a sine tone
// shaped by a linear attack and an exponential decay. Item kinds: schedule
// (store a voice starting at the later of start_req and the cursor; when the
// pool is full the tick is dropped and the sticky dropped flag is set),
// render (mix every voice active at the cursor, saturate to signed Q1.15,
// deliver sample/position/dropped, advance the cursor, free expired voices)
// and clear (empty the pool). Schedule and clear give no item. A render
// walks every voice slot of the voice memory: an idle or silent slot passes
// READ, EVAL and NEXT; an active one passes READ, EVAL, DIV (waiting on the
// 32-step serial divider that forms the envelope index), ROM, MUL1, MUL2 and
// NEXT. The next item is taken while a finished result still waits on the
// output. Register writes take effect at once, also on voices already in
// the pool.
`default_nettype none
`include "assert_macros.svh"
module metronome_click_voice_mixer
  import mcvm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  mcvm_in_if.sink                   in_ch,
  mcvm_out_if.source                out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_ROM  = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [23:0] acc_step_q, beat_step_q, sub_step_q;
  logic [15:0] acc_gain_q, beat_gain_q, sub_gain_q;
  logic [15:0] attack_q, decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_step_q  <= 24'd524288;
      acc_gain_q  <= 16'd52428;
      beat_step_q <= 24'd349525;
      beat_gain_q <= 16'd39321;
      sub_step_q  <= 24'd279620;
      sub_gain_q  <= 16'd26214;
      attack_q    <= 16'd48;
      decay_q     <= 16'd960;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACCENT_STEP: acc_step_q  <= cfg_wdata_i;
        REG_ACCENT_GAIN: acc_gain_q  <= cfg_wdata_i[15:0];
        REG_BEAT_STEP:   beat_step_q <= cfg_wdata_i;
        REG_BEAT_GAIN:   beat_gain_q <= cfg_wdata_i[15:0];
        REG_SUB_STEP:    sub_step_q  <= cfg_wdata_i;
        REG_SUB_GAIN:    sub_gain_q  <= cfg_wdata_i[15:0];
        REG_ATTACK_LEN:  attack_q    <= cfg_wdata_i[15:0];
        REG_DECAY_LEN:   decay_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // A zero decay length counts as one sample.
  logic [15:0]       dl;
  logic [SPAN_W-1:0] span;
  assign dl   = (decay_q == '0) ? 16'd1 : decay_q;
  assign span = SPAN_W'(attack_q) + {1'b0, dl, 3'b000};

  // control state
  logic [CUR_W-1:0]      cursor_q, cursor_d;
  logic [MAX_VOICES-1:0] busy_q, busy_d;
  logic                  drop_q, drop_d;
  logic [VIDX_W-1:0]     vidx_q, vidx_d;
  logic                  out_valid_q, out_valid_d;

  // payload registers
  logic signed [15:0]      out_sample_q, out_sample_d;
  logic [CUR_W-1:0]        out_pos_q, out_pos_d;
  logic                    out_drop_q, out_drop_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [E_W-1:0]          e_q, e_d;
  logic                    in_attack_q, in_attack_d;
  logic [23:0]             step_q, step_d;
  logic [15:0]             gain_q, gain_d;
  logic [23:0]             phase_q;
  logic [ENV_W+15:0]       prod_q, prod_d;

  // voice memory: start sample and tick kind per slot
  logic               ram_we;
  logic [VIDX_W-1:0]  ram_waddr;
  logic [VOICE_W-1:0] ram_wdata;
  logic [VOICE_W-1:0] ram_rdata;
  logic [CUR_W-1:0]   v_start;
  logic [1:0]         v_tone;

  mcvm_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (MAX_VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (vidx_q),
    .rdata_o (ram_rdata)
  );

  assign v_start = ram_rdata[VOICE_W-1:2];
  assign v_tone  = ram_rdata[1:0];

  // envelope divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  mcvm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // input handshake: take an item only between renders
  logic in_acc;
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // lowest free slot
  logic [VIDX_W-1:0] free_idx;
  logic              pool_full;
  always_comb begin
    free_idx  = '0;
    pool_full = 1'b1;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx  = VIDX_W'(i);
        pool_full = 1'b0;
      end
    end
  end

  logic [CUR_W-1:0] sched_start;
  assign sched_start = (in_ch.start_req > cursor_q) ? in_ch.start_req : cursor_q;

  assign ram_we    = in_acc && (in_ch.kind == KIND_SCHED) && (in_ch.tick_kind != TONE_UNUSED)
                     && !pool_full;
  assign ram_waddr = free_idx;
  assign ram_wdata = {sched_start, in_ch.tick_kind};

  // per-slot evaluation, valid in S_EVAL
  logic [CUR_W-1:0] elapsed;
  logic [CUR_W:0]   end_pos;
  logic [CUR_W-1:0] cursor_inc;
  logic             v_active;
  logic             v_expired;
  assign elapsed    = cursor_q - v_start;
  assign cursor_inc = cursor_q + 1'b1;
  assign end_pos    = {1'b0, v_start} + (CUR_W + 1)'(span);
  assign v_active   = busy_q[vidx_q] && (v_start <= cursor_q)
                      && (elapsed < CUR_W'(span)) && (v_tone != TONE_UNUSED);
  assign v_expired  = end_pos <= {1'b0, cursor_inc};

  // table lookups, registered read
  logic [23:0]               phase_w;
  logic [1:0]                quad;
  logic [SINE_TABLE_BITS-1:0] w;
  logic [SINE_TABLE_BITS:0]  sine_addr;
  logic [DECAY_TABLE_BITS-1:0] env_addr;
  logic [SIN_W-1:0]          sine_q;
  logic [ENV_W-1:0]          env_rom_q;
  logic [ENV_W-1:0]          env;
  logic [47:0]               step_prod;

  assign step_prod = 48'(step_q) * 48'(e_q);
  assign phase_w   = step_prod[23:0];
  assign quad      = phase_q[23:22];
  assign w         = phase_q[21 -: SINE_TABLE_BITS];
  assign sine_addr = quad[0] ? ((SINE_TABLE_BITS + 1)'(SINE_N) - {1'b0, w}) : {1'b0, w};
  assign env_addr  = (div_rsp.quot >= QUO_W'(DECAY_N - 1)) ?
                     DECAY_TABLE_BITS'(DECAY_N - 1) : div_rsp.quot[DECAY_TABLE_BITS-1:0];
  assign env       = in_attack_q ? ENV_W'(div_rsp.quot) : env_rom_q;

  always_ff @(posedge clk_i) begin
    phase_q   <= phase_w;
    sine_q    <= SINE_Q15[sine_addr];
    env_rom_q <= DECAY_ENV[env_addr];
  end

  // signed voice term
  logic [ENV_W+SIN_W+15:0] mag_full;
  logic [15:0]             mag;
  logic signed [ACC_W-1:0] term;
  assign mag_full = (ENV_W + SIN_W + 16)'(prod_q) * (ENV_W + SIN_W + 16)'(sine_q);
  assign mag      = mag_full[47:32];
  assign term     = quad[1] ? -$signed(ACC_W'(mag)) : $signed(ACC_W'(mag));

  // saturated mix
  logic signed [15:0] sat;
  always_comb begin
    if (acc_q > ACC_W'(32767)) sat = 16'sh7FFF;
    else if (acc_q < -$signed(ACC_W'(32768))) sat = -16'sh8000;
    else sat = acc_q[15:0];
  end

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    busy_d       = busy_q;
    drop_d       = drop_q;
    vidx_d       = vidx_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_pos_d    = out_pos_q;
    out_drop_d   = out_drop_q;
    acc_d        = acc_q;
    e_d          = e_q;
    in_attack_d  = in_attack_q;
    step_d       = step_q;
    gain_d       = gain_q;
    prod_d       = prod_q;
    div_req      = '0;

    if (out_valid_q && out_ch.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            KIND_SCHED: begin
              if (in_ch.tick_kind != TONE_UNUSED) begin
                if (pool_full) drop_d = 1'b1;
                else busy_d[free_idx] = 1'b1;
              end
            end
            KIND_RENDER: begin
              vidx_d  = '0;
              acc_d   = '0;
              state_d = S_READ;
            end
            KIND_CLEAR: busy_d = '0;
            default: ;
          endcase
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        // drop the slot once its span has run out at the next cursor
        if (busy_q[vidx_q] && v_expired) busy_d[vidx_q] = 1'b0;
        e_d         = elapsed[E_W-1:0];
        in_attack_d = elapsed < CUR_W'(attack_q);
        case (v_tone)
          TONE_ACCENT: begin step_d = acc_step_q;  gain_d = acc_gain_q;  end
          TONE_BEAT:   begin step_d = beat_step_q; gain_d = beat_gain_q; end
          default:     begin step_d = sub_step_q;  gain_d = sub_gain_q;  end
        endcase
        if (v_active) begin
          div_req.start = 1'b1;
          if (elapsed < CUR_W'(attack_q)) begin
            div_req.num = {elapsed[15:0], 16'b0};
            div_req.den = attack_q;
          end else begin
            div_req.num = DIV_W'(E_W'(elapsed[E_W-1:0] - E_W'(attack_q))) << DEC_SHIFT;
            div_req.den = dl;
          end
          state_d = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIV: if (div_rsp.done) state_d = S_ROM;
      S_ROM: state_d = S_MUL1;
      S_MUL1: begin
        prod_d  = (ENV_W + 16)'(gain_q) * (ENV_W + 16)'(env);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = acc_q + term;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (vidx_q == VIDX_W'(MAX_VOICES - 1)) begin
          state_d = S_OUT;
        end else begin
          vidx_d  = vidx_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d  = 1'b1;
          out_sample_d = sat;
          out_pos_d    = cursor_q;
          out_drop_d   = drop_q;
          drop_d       = 1'b0;
          cursor_d     = cursor_inc;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      busy_q      <= '0;
      drop_q      <= 1'b0;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      busy_q      <= busy_d;
      drop_q      <= drop_d;
      vidx_q      <= vidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_pos_q    <= out_pos_d;
    out_drop_q   <= out_drop_d;
    acc_q        <= acc_d;
    e_q          <= e_d;
    in_attack_q  <= in_attack_d;
    step_q       <= step_d;
    gain_q       <= gain_d;
    prod_q       <= prod_d;
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.sample   = out_sample_q;
  assign out_ch.position = out_pos_q;
  assign out_ch.dropped  = out_drop_q;

  `ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
               in_acc && (in_ch.kind == KIND_CLEAR), busy_q == '0)
  `ASSERT_CLK(a_drop_when_full, clk_i, rst_ni, $rose(drop_q) |-> $past(busy_q) == '1)
  `ASSERT_CLK(a_result_after_walk, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_OUT)
  `ASSERT_NEXT(a_walk_visits_all, clk_i, rst_ni, state_q == S_NEXT && state_d == S_OUT,
               vidx_q == VIDX_W'(MAX_VOICES - 1))

endmodule
`default_nettype wire

>>> tb/sv/metronome_click_voice_mixer_checker.sv
module metronome_click_voice_mixer_checker
  import mcvm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mcvm_in_if                   in_ch,
  mcvm_out_if                  out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  output int                   pending_o,
  output int                   errors_o
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic [47:0]        position;
    logic               dropped;
  } mix_out_t;

  mix_out_t mix_q[$];

  logic [23:0] tone_step [3];
  logic [15:0] tone_gain [3];
  logic [15:0] attack_len;
  logic [15:0] decay_len;
  logic [47:0] cursor;
  logic        busy [MAX_VOICES];
  logic [47:0] vstart [MAX_VOICES];
  logic [1:0]  vtone [MAX_VOICES];
  logic        drop_flag;
  int          errors;

  longint unsigned sine_tab [SINE_N+1];
  longint unsigned env_tab [DECAY_N];

  // Quarter-wave sine (Q15) and decay envelope (Q16) tables.
  initial begin
    longint unsigned a, a2, term, x, y, r;
    longint sum;
    for (int i = 0; i <= SINE_N; i++) begin
      a    = (64'(HALF_PI_Q30) * 64'(i)) >> SINE_TABLE_BITS;
      a2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
        sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      x = (longint'(sum) + 16384) >> 15;
      sine_tab[i] = (x > 32767) ? 32767 : x;
    end
    y    = 64'd1 << (35 - DECAY_TABLE_BITS);
    term = 64'd1 << 32;
    sum  = longint'(64'd1 << 32);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * y) >> 32) / longint'(k);
      sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
    end
    r = longint'(sum);
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    x = 64'd1 << 32;
    for (int i = 0; i < DECAY_N; i++) begin
      if (i > 0) x = (x * r) >> 32;
      env_tab[i] = (x + 32768) >> 16;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    longint unsigned dl, span, e, idx, env, ph, w, mag;
    logic [1:0] quad;
    longint acc;
    int slot;
    mix_out_t want, got;
    if (!rst_ni) begin
      tone_step[TONE_ACCENT] = 24'd524288;
      tone_gain[TONE_ACCENT] = 16'd52428;
      tone_step[TONE_BEAT]   = 24'd349525;
      tone_gain[TONE_BEAT]   = 16'd39321;
      tone_step[TONE_SUB]    = 24'd279620;
      tone_gain[TONE_SUB]    = 16'd26214;
      attack_len = 16'd48;
      decay_len  = 16'd960;
      cursor     = '0;
      drop_flag  = 1'b0;
      errors     = 0;
      for (int i = 0; i < MAX_VOICES; i++) busy[i] = 1'b0;
      mix_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample, out_ch.position, out_ch.dropped};
        if (mix_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected sample: sample %0d position %0d dropped %0b",
                     got.sample, got.position, got.dropped);
        end else begin
          want = mix_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: sample %0d/%0d position %0d/%0d dropped %0b/%0b",
                       want.sample, got.sample, want.position, got.position,
                       want.dropped, got.dropped);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACCENT_STEP: tone_step[TONE_ACCENT] = cfg_wdata_i[23:0];
          REG_ACCENT_GAIN: tone_gain[TONE_ACCENT] = cfg_wdata_i[15:0];
          REG_BEAT_STEP:   tone_step[TONE_BEAT]   = cfg_wdata_i[23:0];
          REG_BEAT_GAIN:   tone_gain[TONE_BEAT]   = cfg_wdata_i[15:0];
          REG_SUB_STEP:    tone_step[TONE_SUB]    = cfg_wdata_i[23:0];
          REG_SUB_GAIN:    tone_gain[TONE_SUB]    = cfg_wdata_i[15:0];
          REG_ATTACK_LEN:  attack_len = cfg_wdata_i[15:0];
          REG_DECAY_LEN:   decay_len  = cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_SCHED: if (in_ch.tick_kind <= TONE_SUB) begin
            slot = -1;
            for (int i = MAX_VOICES - 1; i >= 0; i--) if (!busy[i]) slot = i;
            if (slot < 0) drop_flag = 1'b1;
            else begin
              busy[slot]   = 1'b1;
              vstart[slot] = (in_ch.start_req > cursor) ? in_ch.start_req : cursor;
              vtone[slot]  = in_ch.tick_kind;
            end
          end
          KIND_CLEAR: for (int i = 0; i < MAX_VOICES; i++) busy[i] = 1'b0;
          KIND_RENDER: begin
            dl   = (decay_len == 0) ? 1 : decay_len;
            span = longint'(attack_len) + 8 * dl;
            acc  = 0;
            for (int i = 0; i < MAX_VOICES; i++) begin
              if (busy[i] && vstart[i] <= cursor && longint'(cursor - vstart[i]) < span) begin
                e = cursor - vstart[i];
                if (e < attack_len) env = (e << 16) / attack_len;
                else begin
                  idx = ((e - attack_len) << DECAY_TABLE_BITS) / (8 * dl);
                  if (idx >= DECAY_N) idx = DECAY_N - 1;
                  env = env_tab[idx];
                end
                ph   = (longint'(tone_step[vtone[i]]) * e) & 64'hFF_FFFF;
                quad = ph[23:22];
                w    = (ph >> (22 - SINE_TABLE_BITS)) & (SINE_N - 1);
                mag  = (longint'(tone_gain[vtone[i]]) * env *
                        sine_tab[quad[0] ? SINE_N - w : w]) >> 32;
                acc  = quad[1] ? acc - longint'(mag) : acc + longint'(mag);
              end
            end
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            want.sample   = acc[15:0];
            want.position = cursor;
            want.dropped  = drop_flag;
            mix_q = {mix_q, want};
            drop_flag = 1'b0;
            cursor    = cursor + 48'd1;
            for (int i = 0; i < MAX_VOICES; i++)
              if (busy[i] && longint'(vstart[i]) + span <= longint'(cursor)) busy[i] = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending_o <= mix_q.size();
    errors_o  <= errors;
  end

endmodule

>>> tb/sv/metronome_click_voice_mixer_tb.sv
module metronome_click_voice_mixer_tb;
  import mcvm_pkg::*;

  // Settle margin: room for the longest render, which runs the divider for every slot.
  localparam int SETTLE    = 40 * MAX_VOICES + 20;
  localparam int LIMIT     = 3000000;
  localparam int PHASE_LEN = 150;

  // Out-of-range codes that the block must ignore.
  localparam logic [1:0]           KIND_BAD   = 2'd3;
  localparam logic [1:0]           TONE_BAD   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  typedef logic [CFG_DAT_W-1:0] reg_set_t [8];

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int                   pending;
  int                   errors;
  int unsigned          cycles;
  int                   send_calm;
  int                   recv_calm;
  logic [47:0]          renders_sent;

  mcvm_in_if  in_ch ();
  mcvm_out_if out_ch ();

  metronome_click_voice_mixer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  metronome_click_voice_mixer_checker mix_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait length per item, drawn at random, with occasional stretches of back-to-back items.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  // Hard stop so a hung handshake cannot run forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("metronome_click_voice_mixer_tb failed");
      $finish;
    end
  end

  // Consumer side: stall ready for a random count before each item.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_ch.valid);
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one item after a random gap; hold valid until it is taken.
  task automatic send(input logic [1:0] kind, input logic [47:0] at, input logic [1:0] tk);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.start_req <= at;
    in_ch.tick_kind <= tk;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_RENDER) renders_sent++;
  endtask

  // Drain: drop valid, wait for every sample, then let a trailing item finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(input reg_set_t v);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int          r;
    logic [47:0] at;
    logic [1:0]  tk;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      tk = ($urandom_range(0, 29) == 0) ? TONE_BAD : 2'($urandom_range(0, 2));
      if (r < 20) begin
        // Mostly near the cursor so voices overlap and sound; some in the past.
        at = renders_sent + 48'($urandom_range(0, 8)) - 48'($urandom_range(0, 2));
        send(KIND_SCHED, at, tk);
      end else if (r < 24) begin
        at = {$urandom(), 16'($urandom())};
        send(KIND_SCHED, at, 2'($urandom_range(0, 3)));
      end else if (r < 27) begin
        send(KIND_CLEAR, {$urandom(), 16'($urandom())}, tk);
      end else if (r < 29) begin
        send(KIND_BAD, {$urandom(), 16'($urandom())}, tk);
      end else begin
        send(KIND_RENDER, {$urandom(), 16'($urandom())}, tk);
      end
    end
  endtask

  initial begin
    reg_set_t regs;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_SCHED;
    in_ch.start_req <= '0;
    in_ch.tick_kind <= TONE_ACCENT;
    cycles       = 0;
    send_calm    = 0;
    recv_calm    = 0;
    renders_sent = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pool, all tones, ignored codes, past and far starts,
    // pool overflow with the sticky drop flag, clear.
    send(KIND_RENDER, '0, TONE_ACCENT);
    send(KIND_SCHED, '0, TONE_ACCENT);
    send(KIND_SCHED, '0, TONE_BEAT);
    send(KIND_SCHED, 48'd3, TONE_SUB);
    send(KIND_SCHED, '0, TONE_BAD);
    send(KIND_BAD, 48'hFFFF_FFFF_FFFF, TONE_BAD);
    repeat (5) send(KIND_RENDER, '0, TONE_ACCENT);
    send(KIND_SCHED, '0, TONE_BEAT);
    send(KIND_SCHED, 48'hFFFF_FFFF_FFFF, TONE_ACCENT);
    repeat (12) send(KIND_SCHED, renders_sent, TONE_SUB);
    send(KIND_RENDER, '0, TONE_ACCENT);
    send(KIND_RENDER, '0, TONE_ACCENT);
    send(KIND_CLEAR, '0, TONE_ACCENT);
    send(KIND_RENDER, '0, TONE_ACCENT);
    run_random(PHASE_LEN);

    // Everything at its top value: short voices, loud enough to saturate.
    settle();
    regs = '{24'hFF_FFFF, 24'hFFFF, 24'hFF_FFFF, 24'hFFFF,
             24'hFF_FFFF, 24'hFFFF, 24'd1, 24'd1};
    load_regs(regs);
    run_random(PHASE_LEN);

    // All zero: no attack, decay treated as one, silent tones.
    settle();
    regs = '{default: '0};
    load_regs(regs);
    run_random(PHASE_LEN);

    // Unused index first; then upper bits set on the narrow registers must be dropped.
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= 24'hFF_FFFF;
    @(posedge clk);
    regs = '{24'h80_0001, 24'hFF_8000, 24'h40_0000, 24'h12_FFFF,
             24'hC0_0000, 24'h01_7FFF, 24'hAB_0000, 24'h56_0003};
    load_regs(regs);
    run_random(PHASE_LEN);

    // Longest envelope.
    settle();
    regs = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
             24'($urandom()), 24'($urandom()), 24'hFFFF, 24'hFFFF};
    load_regs(regs);
    run_random(PHASE_LEN);

    // Random settings with short voices so they expire and recycle.
    repeat (2) begin
      settle();
      regs = '{24'($urandom()), 24'($urandom_range(0, 65535)), 24'($urandom()),
               24'($urandom_range(0, 65535)), 24'($urandom()),
               24'($urandom_range(0, 65535)), 24'($urandom_range(0, 40)),
               24'($urandom_range(0, 12))};
      load_regs(regs);
      run_random(PHASE_LEN);
    end

    settle();
    if (errors == 0) $display("metronome_click_voice_mixer_tb passed");
    else $display("metronome_click_voice_mixer_tb failed");
    $finish;
  end

endmodule
